>>> rtl/hsvr_pkg.sv
// shared types, constants and microcode encodings for the hsv rainbow pixel generator
package hsvr_pkg;

   // field widths
   localparam int BYTE_W     = 8;
   localparam int PIX_W      = 5;
   localparam int CH_W       = 2;
   localparam int HUE_W      = 9;
   localparam int SECT_W     = 3;
   localparam int REM_W      = 6;
   localparam int STEP_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // pixel count default and its upper bound
   localparam int PIXEL_COUNT_DEF = 2;
   localparam int MAX_PIXELS      = 21;

   // hue geometry
   localparam int SECTOR_DEG_I  = 60;
   localparam int FULL_CIRCLE_I = 360;

   // frac = floor(rem * 256 / 60) = (rem * 4370) >> 10 for rem in 0..59
   localparam int               FRAC_MUL_W = 13;
   localparam logic [12:0]      FRAC_MUL   = 13'd4370;
   localparam int               FRAC_SHIFT = 10;

   // register reset values
   localparam logic [BYTE_W-1:0] SAT_RST   = 8'd255;
   localparam logic [BYTE_W-1:0] BRI_RST   = 8'd40;
   localparam logic [HUE_W-1:0]  HSTEP_RST = 9'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SATURATION = 2'd0,
      CSR_BRIGHTNESS = 2'd1,
      CSR_HUE_STEP   = 2'd2
   } csr_index_type;

   typedef enum logic [CH_W-1:0] {
      CH_GREEN = 2'd0,
      CH_RED   = 2'd1,
      CH_BLUE  = 2'd2
   } chan_type;

   typedef enum logic [2:0] {
      OP_IDLE   = 3'd0,
      OP_DECODE = 3'd1,
      OP_MUL    = 3'd2,
      OP_MAP    = 3'd3,
      OP_EMIT   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      JMP_NEXT       = 2'd0,
      JMP_WAIT_ITEM  = 2'd1,
      JMP_IF_BLANK   = 2'd2,
      JMP_WAIT_FRAME = 2'd3
   } jump_type;

   typedef enum logic {
      MA_VALUE = 1'b0,
      MA_SAT   = 1'b1
   } mul_a_type;

   typedef enum logic [1:0] {
      MB_INV_SAT  = 2'd0,
      MB_FRAC     = 2'd1,
      MB_INV_FRAC = 2'd2,
      MB_INV_TMP  = 2'd3
   } mul_b_type;

   typedef enum logic [1:0] {
      DST_P   = 2'd0,
      DST_Q   = 2'd1,
      DST_T   = 2'd2,
      DST_TMP = 2'd3
   } dst_type;

   typedef logic [STEP_W-1:0] step_type;

   // program addresses
   localparam step_type ST_IDLE   = 4'd0;
   localparam step_type ST_DECODE = 4'd1;
   localparam step_type ST_MUL_P  = 4'd2;
   localparam step_type ST_MUL_A  = 4'd3;
   localparam step_type ST_MUL_Q  = 4'd4;
   localparam step_type ST_MUL_B  = 4'd5;
   localparam step_type ST_MUL_T  = 4'd6;
   localparam step_type ST_MAP    = 4'd7;
   localparam step_type ST_EMIT   = 4'd8;

   typedef struct packed {
      jump_type  jump;
      step_type  target;
      op_type    op;
      mul_a_type ma;
      mul_b_type mb;
      dst_type   dst;
   } uword_type;

   // sequencer to datapath
   typedef struct packed {
      op_type    op;
      mul_a_type ma;
      mul_b_type mb;
      dst_type   dst;
      logic      take_item;
      logic      beat_taken;
   } ctl_type;

   // datapath to sequencer
   typedef struct packed {
      logic run;
      logic frame_end;
   } stat_type;

endpackage

>>> rtl/hsvr_ucode_rom.sv
// control store: one control word per program step
module hsvr_ucode_rom
   import hsvr_pkg::*;
(
   input  step_type  pc,
   output uword_type uword
);

   always_comb begin
      unique case (pc)
         ST_IDLE:   uword = '{JMP_WAIT_ITEM,  ST_IDLE,  OP_IDLE,   MA_VALUE, MB_INV_SAT,  DST_P};
         ST_DECODE: uword = '{JMP_IF_BLANK,   ST_EMIT,  OP_DECODE, MA_VALUE, MB_INV_SAT,  DST_P};
         ST_MUL_P:  uword = '{JMP_NEXT,       ST_IDLE,  OP_MUL,    MA_VALUE, MB_INV_SAT,  DST_P};
         ST_MUL_A:  uword = '{JMP_NEXT,       ST_IDLE,  OP_MUL,    MA_SAT,   MB_FRAC,     DST_TMP};
         ST_MUL_Q:  uword = '{JMP_NEXT,       ST_IDLE,  OP_MUL,    MA_VALUE, MB_INV_TMP,  DST_Q};
         ST_MUL_B:  uword = '{JMP_NEXT,       ST_IDLE,  OP_MUL,    MA_SAT,   MB_INV_FRAC, DST_TMP};
         ST_MUL_T:  uword = '{JMP_NEXT,       ST_IDLE,  OP_MUL,    MA_VALUE, MB_INV_TMP,  DST_T};
         ST_MAP:    uword = '{JMP_NEXT,       ST_IDLE,  OP_MAP,    MA_VALUE, MB_INV_SAT,  DST_P};
         ST_EMIT:   uword = '{JMP_WAIT_FRAME, ST_IDLE,  OP_EMIT,   MA_VALUE, MB_INV_SAT,  DST_P};
         // unused addresses carry an idle control word and step on until the counter wraps to idle
         default:   uword = '{JMP_NEXT,       ST_IDLE,  OP_IDLE,   MA_VALUE, MB_INV_SAT,  DST_P};
      endcase
   end

endmodule

>>> rtl/hsvr_datapath.sv
// hue state, shared 8x8 multiplier, colour registers and beat counters
module hsvr_datapath
   import hsvr_pkg::*;
#(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ctl_type           ctl,
   input  logic [BYTE_W-1:0] saturation,
   input  logic [BYTE_W-1:0] brightness,
   input  logic [HUE_W-1:0]  hue_step,
   input  logic              req_run,
   output stat_type          stat,
   output logic [BYTE_W-1:0] data_byte,
   output logic [PIX_W-1:0]  pixel_index,
   output logic [CH_W-1:0]   channel,
   output logic              last
);

   // strip length held to 1..MAX_PIXELS
   localparam int NUM_PIX = (PIXEL_COUNT < 1) ? 1 :
                            (PIXEL_COUNT > MAX_PIXELS) ? MAX_PIXELS : PIXEL_COUNT;

   localparam logic [PIX_W-1:0]  LAST_PIX = PIX_W'(NUM_PIX - 1);
   localparam logic [HUE_W-1:0]  BND1 = HUE_W'(SECTOR_DEG_I);
   localparam logic [HUE_W-1:0]  BND2 = HUE_W'(2 * SECTOR_DEG_I);
   localparam logic [HUE_W-1:0]  BND3 = HUE_W'(3 * SECTOR_DEG_I);
   localparam logic [HUE_W-1:0]  BND4 = HUE_W'(4 * SECTOR_DEG_I);
   localparam logic [HUE_W-1:0]  BND5 = HUE_W'(5 * SECTOR_DEG_I);
   localparam logic [HUE_W:0]    CIRC1 = (HUE_W + 1)'(FULL_CIRCLE_I);
   localparam logic [HUE_W:0]    CIRC2 = (HUE_W + 1)'(2 * FULL_CIRCLE_I);

   logic                run_ff, run_in;
   logic [HUE_W-1:0]    hue_ff, hue_in;
   logic [SECT_W-1:0]   sector_ff, sector_in;
   logic [BYTE_W-1:0]   frac_ff, frac_in;
   logic [BYTE_W-1:0]   p_ff, p_in, q_ff, q_in, t_ff, t_in, tmp_ff, tmp_in;
   logic [BYTE_W-1:0]   g_ff, g_in, r_ff, r_in, b_ff, b_in;
   logic [PIX_W-1:0]    pix_ff, pix_in;
   chan_type            chan_ff, chan_in;

   logic [SECT_W-1:0]             sector;
   logic [HUE_W-1:0]              rem_full;
   logic [REM_W+FRAC_MUL_W-1:0]   frac_wide;
   logic [BYTE_W-1:0]             mul_a, mul_b;
   logic [2*BYTE_W-1:0]           prod;
   logic [HUE_W:0]                hue_sum;
   logic [HUE_W:0]                hue_wrap;

   // sector and remainder within the sector
   always_comb begin
      if (hue_ff < BND1) begin
         sector = 3'd0; rem_full = hue_ff;
      end else if (hue_ff < BND2) begin
         sector = 3'd1; rem_full = hue_ff - BND1;
      end else if (hue_ff < BND3) begin
         sector = 3'd2; rem_full = hue_ff - BND2;
      end else if (hue_ff < BND4) begin
         sector = 3'd3; rem_full = hue_ff - BND3;
      end else if (hue_ff < BND5) begin
         sector = 3'd4; rem_full = hue_ff - BND4;
      end else begin
         sector = 3'd5; rem_full = hue_ff - BND5;
      end
      frac_wide = rem_full[REM_W-1:0] * FRAC_MUL;
   end

   // shared multiplier, inverse terms are 255 - x
   always_comb begin
      mul_a = (ctl.ma == MA_VALUE) ? brightness : saturation;
      case (ctl.mb)
         MB_INV_SAT:  mul_b = ~saturation;
         MB_FRAC:     mul_b = frac_ff;
         MB_INV_FRAC: mul_b = ~frac_ff;
         MB_INV_TMP:  mul_b = ~tmp_ff;
         default:     mul_b = ~saturation;
      endcase
      prod = mul_a * mul_b;
   end

   // hue advance, sum stays below three circles
   always_comb begin
      hue_sum = {1'b0, hue_ff} + {1'b0, hue_step};
      if (hue_sum >= CIRC2) begin
         hue_wrap = hue_sum - CIRC2;
      end else if (hue_sum >= CIRC1) begin
         hue_wrap = hue_sum - CIRC1;
      end else begin
         hue_wrap = hue_sum;
      end
   end

   always_comb begin
      run_in    = run_ff;
      hue_in    = hue_ff;
      sector_in = sector_ff;
      frac_in   = frac_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      t_in      = t_ff;
      tmp_in    = tmp_ff;
      g_in      = g_ff;
      r_in      = r_ff;
      b_in      = b_ff;
      pix_in    = pix_ff;
      chan_in   = chan_ff;

      if (ctl.take_item) begin
         run_in = req_run;
      end

      case (ctl.op)
         OP_DECODE: begin
            sector_in = sector;
            frac_in   = frac_wide[FRAC_SHIFT +: BYTE_W];
            pix_in    = '0;
            chan_in   = CH_GREEN;
            if (!run_ff) begin
               g_in   = '0;
               r_in   = '0;
               b_in   = '0;
               hue_in = '0;
            end
         end
         OP_MUL: begin
            case (ctl.dst)
               DST_P:   p_in   = prod[2*BYTE_W-1:BYTE_W];
               DST_Q:   q_in   = prod[2*BYTE_W-1:BYTE_W];
               DST_T:   t_in   = prod[2*BYTE_W-1:BYTE_W];
               DST_TMP: tmp_in = prod[2*BYTE_W-1:BYTE_W];
               default: tmp_in = prod[2*BYTE_W-1:BYTE_W];
            endcase
         end
         OP_MAP: begin
            hue_in = hue_wrap[HUE_W-1:0];
            unique case (sector_ff)
               3'd0:    begin r_in = brightness; g_in = t_ff;       b_in = p_ff;       end
               3'd1:    begin r_in = q_ff;       g_in = brightness; b_in = p_ff;       end
               3'd2:    begin r_in = p_ff;       g_in = brightness; b_in = t_ff;       end
               3'd3:    begin r_in = p_ff;       g_in = q_ff;       b_in = brightness; end
               3'd4:    begin r_in = t_ff;       g_in = p_ff;       b_in = brightness; end
               default: begin r_in = brightness; g_in = p_ff;       b_in = q_ff;       end
            endcase
         end
         default: begin
         end
      endcase

      // wire order green, red, blue per pixel
      if (ctl.beat_taken) begin
         if (chan_ff == CH_BLUE) begin
            chan_in = CH_GREEN;
            pix_in  = pix_ff + PIX_W'(1);
         end else begin
            chan_in = chan_type'(chan_ff + CH_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff  <= '0;
         pix_ff  <= '0;
         chan_ff <= CH_GREEN;
      end else begin
         hue_ff  <= hue_in;
         pix_ff  <= pix_in;
         chan_ff <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff    <= run_in;
      sector_ff <= sector_in;
      frac_ff   <= frac_in;
      p_ff      <= p_in;
      q_ff      <= q_in;
      t_ff      <= t_in;
      tmp_ff    <= tmp_in;
      g_ff      <= g_in;
      r_ff      <= r_in;
      b_ff      <= b_in;
   end

   always_comb begin
      case (chan_ff)
         CH_GREEN: data_byte = g_ff;
         CH_RED:   data_byte = r_ff;
         CH_BLUE:  data_byte = b_ff;
         default:  data_byte = b_ff;
      endcase
   end

   assign pixel_index    = pix_ff;
   assign channel        = chan_ff;
   assign last           = (pix_ff == LAST_PIX) && (chan_ff == CH_BLUE);
   assign stat.run       = run_ff;
   assign stat.frame_end = last;

endmodule

>>> rtl/hsv_rainbow_pixel_generator_core.sv
// top level: microcode sequencer, configuration registers and stream ports
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata[0] run
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata byte, pixel; tuser channel; tlast last
//  csr     | in  | csr_we                 | csr_index, csr_wdata
//
//  running frame: accept, decode, 5 multiply steps, map, then 3*NUM_PIX beats
//  blank frame:   accept, decode, then 3*NUM_PIX beats
//  the shared 8x8 multiplier takes one product per step, which sets the five steps
//  one item at a time: req_tready is high only at the idle step
//  a stalled rsp_tready holds the current beat and the program counter
//  synchronous reset returns to idle, hue 0 and register reset values
module hsv_rainbow_pixel_generator_core
   import hsvr_pkg::*;
#(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] run, rest zero
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] data_byte, [12:8] pixel_index,
                                              // [15:13] zero
   output logic [CH_W-1:0]       rsp_tuser,   // [1:0] channel
   output logic                  rsp_tlast,   // last byte of the frame
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // strip length held to 1..MAX_PIXELS
   localparam int NUM_PIX = (PIXEL_COUNT < 1) ? 1 :
                            (PIXEL_COUNT > MAX_PIXELS) ? MAX_PIXELS : PIXEL_COUNT;
   localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(NUM_PIX - 1);

   // program counter of the sequencer
   step_type  pc_ff, pc_in;
   uword_type uword;
   ctl_type   ctl;
   stat_type  stat;

   // configuration registers
   logic [BYTE_W-1:0] sat_ff, sat_in;
   logic [BYTE_W-1:0] bri_ff, bri_in;
   logic [HUE_W-1:0]  hstep_ff, hstep_in;

   logic [BYTE_W-1:0] data_byte;
   logic [PIX_W-1:0]  pixel_index;
   logic [CH_W-1:0]   channel;
   logic              last;
   logic              take_item;
   logic              beat_taken;

   hsvr_ucode_rom u_rom (
      .pc    (pc_ff),
      .uword (uword)
   );

   // handshakes come straight from the current control word
   assign req_tready = (uword.op == OP_IDLE);
   assign rsp_tvalid = (uword.op == OP_EMIT);
   assign take_item  = req_tvalid && req_tready;
   assign beat_taken = rsp_tvalid && rsp_tready;

   assign ctl.op         = uword.op;
   assign ctl.ma         = uword.ma;
   assign ctl.mb         = uword.mb;
   assign ctl.dst        = uword.dst;
   assign ctl.take_item  = take_item;
   assign ctl.beat_taken = beat_taken;

   // next address: step, hold, or conditional jump
   always_comb begin
      pc_in = pc_ff;
      unique case (uword.jump)
         JMP_NEXT: begin
            pc_in = pc_ff + STEP_W'(1);
         end
         JMP_WAIT_ITEM: begin
            if (take_item) begin
               pc_in = pc_ff + STEP_W'(1);
            end
         end
         JMP_IF_BLANK: begin
            // blank frame skips the colour math
            pc_in = stat.run ? pc_ff + STEP_W'(1) : uword.target;
         end
         JMP_WAIT_FRAME: begin
            if (beat_taken && stat.frame_end) begin
               pc_in = uword.target;
            end
         end
         default: begin
            pc_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // register writes, unknown index is dropped
   always_comb begin
      sat_in   = sat_ff;
      bri_in   = bri_ff;
      hstep_in = hstep_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SATURATION: sat_in   = csr_wdata[BYTE_W-1:0];
            CSR_BRIGHTNESS: bri_in   = csr_wdata[BYTE_W-1:0];
            CSR_HUE_STEP:   hstep_in = csr_wdata[HUE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff   <= SAT_RST;
         bri_ff   <= BRI_RST;
         hstep_ff <= HSTEP_RST;
      end else begin
         sat_ff   <= sat_in;
         bri_ff   <= bri_in;
         hstep_ff <= hstep_in;
      end
   end

   hsvr_datapath #(
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .saturation  (sat_ff),
      .brightness  (bri_ff),
      .hue_step    (hstep_ff),
      .req_run     (req_tdata[0]),
      .stat        (stat),
      .data_byte   (data_byte),
      .pixel_index (pixel_index),
      .channel     (channel),
      .last        (last)
   );

   assign rsp_tdata = {3'b000, pixel_index, data_byte};
   assign rsp_tuser = channel;
   assign rsp_tlast = last;

   // the two streams never overlap in this sequential schedule
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a frame is being sent");

   // the last beat returns the sequencer to idle
   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("sequencer did not return to idle after last beat");

   // a blank frame carries only zero bytes
   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !stat.run) |-> (data_byte == '0))
      else $error("nonzero byte in blank frame");

   // every frame starts at pixel 0, green
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (pixel_index == '0) && (channel == CH_GREEN))
      else $error("frame did not start at first pixel");

   // beat counters stay inside the strip
   a_pix_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pixel_index <= LAST_PIX) && (channel != 2'd3))
      else $error("beat outside the strip");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the hsv rainbow pixel generator core
module testbench;
   import hsvr_pkg::*;

   // ---------------------------------------------------------------------------------------
   // run shape
   // ---------------------------------------------------------------------------------------
   localparam int NUM_PIXELS      = PIXEL_COUNT_DEF;
   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 4;
   localparam int IDLE_PCT        = 29;       // chance of a gap or a stall per cycle
   localparam int RUN_PCT         = 85;       // most random ticks draw a colored frame
   localparam int NUM_PHASES      = 7;        // random configuration phases
   localparam int TICKS_PER_PHASE = 13;
   localparam int QUIET_PHASE     = 2;        // phase with no idling on either side
   localparam int PRESSURE_PHASE  = 4;        // phase that opens with a long receiver hold
   localparam int HOLD_CYCLES     = 150;
   localparam int SETTLE_CYCLES   = 4;        // idle cycles before a register write
   localparam int DRAIN_CYCLES    = 20;       // quiet tail once nothing is due
   localparam int DRAIN_LIMIT     = 2000;     // bound on the wait for the last beats
   localparam int TIMEOUT_NS      = 2_000_000;

   // index past the end of the register list, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // one colour byte as it should leave the block
   typedef struct {
      logic [BYTE_W-1:0] data_byte;
      logic [PIX_W-1:0]  pixel_index;
      logic [CH_W-1:0]   channel;
      logic              is_last;
   } strip_byte_type;

   // directed stimulus row: a register write or a frame tick
   typedef enum logic {
      ROW_CSR  = 1'b0,
      ROW_TICK = 1'b1
   } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
      logic                  run;
      logic                  typed;     // colour below is written out by hand
      logic [BYTE_W-1:0]     green;
      logic [BYTE_W-1:0]     red;
      logic [BYTE_W-1:0]     blue;
   } stim_row_type;

   // ---------------------------------------------------------------------------------------
   // block ports, every input known from time zero
   // ---------------------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;     // [0] run, rest zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;           // [7:0] data_byte, [12:8] pixel_index,
                                               // [15:13] zero
   logic [CH_W-1:0]       rsp_tuser;           // [1:0] channel
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // ---------------------------------------------------------------------------------------
   // predictor state: a private copy of the hue and the three registers
   // ---------------------------------------------------------------------------------------
   logic [HUE_W-1:0]      hue_deg  = '0;
   logic [BYTE_W-1:0]     sat_val  = SAT_RST;
   logic [BYTE_W-1:0]     bri_val  = BRI_RST;
   logic [HUE_W-1:0]      step_val = HSTEP_RST;

   strip_byte_type        bytes_due [$];       // colour bytes still owed by the block
   strip_byte_type        next_due;
   stim_row_type          directed_rows [$];

   bit                    quiet            = 1'b0;
   bit                    hold_off_request = 1'b0;
   int                    fail_count       = 0;
   int                    ticks_sent       = 0;
   int                    blanks_sent      = 0;
   int                    beats_checked    = 0;
   int                    reg_writes       = 0;

   hsv_rainbow_pixel_generator_core #(
      .PIXEL_COUNT (NUM_PIXELS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // colour math: six 60 degree sectors, remainder scaled by 256/60 to 0..251,
   // p/q/t as 8x8 products shifted right by 8
   // ---------------------------------------------------------------------------------------
   function automatic void hsv_to_grb(input logic [HUE_W-1:0] hue,
                                      input logic [BYTE_W-1:0] sat,
                                      input logic [BYTE_W-1:0] val,
                                      output logic [BYTE_W-1:0] green,
                                      output logic [BYTE_W-1:0] red,
                                      output logic [BYTE_W-1:0] blue);
      int unsigned h, s, v, frac, p, q, t;
      h    = hue;
      s    = sat;
      v    = val;
      frac = ((h % SECTOR_DEG_I) * 256) / SECTOR_DEG_I;
      p    = (v * (255 - s)) >> 8;
      q    = (v * (255 - ((s * frac) >> 8))) >> 8;
      t    = (v * (255 - ((s * (255 - frac)) >> 8))) >> 8;
      case (h / SECTOR_DEG_I)
         0: begin
            red = 8'(v); green = 8'(t); blue = 8'(p);
         end
         1: begin
            red = 8'(q); green = 8'(v); blue = 8'(p);
         end
         2: begin
            red = 8'(p); green = 8'(v); blue = 8'(t);
         end
         3: begin
            red = 8'(p); green = 8'(q); blue = 8'(v);
         end
         4: begin
            red = 8'(t); green = 8'(p); blue = 8'(v);
         end
         default: begin
            red = 8'(v); green = 8'(p); blue = 8'(q);
         end
      endcase
   endfunction

   // colour of the next frame, then the hue moves on (or back to zero on a blank)
   function automatic void frame_colors(input logic run,
                                        output logic [BYTE_W-1:0] green,
                                        output logic [BYTE_W-1:0] red,
                                        output logic [BYTE_W-1:0] blue);
      if (run) begin
         hsv_to_grb(hue_deg, sat_val, bri_val, green, red, blue);
         // a step above 359 still wraps, the sum stays below three circles
         hue_deg = HUE_W'((int'(hue_deg) + int'(step_val)) % FULL_CIRCLE_I);
      end else begin
         green   = '0;
         red     = '0;
         blue    = '0;
         hue_deg = '0;
      end
   endfunction

   // every pixel repeats the colour in wire order green, red, blue
   function automatic void queue_frame(input logic [BYTE_W-1:0] green,
                                       input logic [BYTE_W-1:0] red,
                                       input logic [BYTE_W-1:0] blue);
      chan_type          order [3] = '{CH_GREEN, CH_RED, CH_BLUE};
      logic [BYTE_W-1:0] level [3];
      strip_byte_type    beat;
      level = '{green, red, blue};
      for (int px = 0; px < NUM_PIXELS; px++) begin
         for (int ch = 0; ch < 3; ch++) begin
            beat.data_byte   = level[ch];
            beat.pixel_index = PIX_W'(px);
            beat.channel     = order[ch];
            beat.is_last     = (px == NUM_PIXELS - 1) && (order[ch] == CH_BLUE);
            bytes_due.push_back(beat);
         end
      end
   endfunction

   function automatic void add_tick(input logic run, input logic typed,
                                    input logic [BYTE_W-1:0] green,
                                    input logic [BYTE_W-1:0] red,
                                    input logic [BYTE_W-1:0] blue);
      directed_rows.push_back('{ROW_TICK, '0, '0, run, typed, green, red, blue});
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] value);
      directed_rows.push_back('{ROW_CSR, idx, value, 1'b0, 1'b0, '0, '0, '0});
   endfunction

   // random register value with the two ends drawn more often
   function automatic logic [CSR_DATA_W-1:0] pick_setting();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return '1;
      return CSR_DATA_W'($urandom_range(2 ** CSR_DATA_W - 1));
   endfunction

   // ---------------------------------------------------------------------------------------
   // drivers, all called at a rising edge and driving with nonblocking assignments
   // ---------------------------------------------------------------------------------------

   // one frame tick: optional gap, offer, wait for the handshake, then predict
   task automatic send_tick(input logic run, input logic typed,
                            input logic [BYTE_W-1:0] exp_green,
                            input logic [BYTE_W-1:0] exp_red,
                            input logic [BYTE_W-1:0] exp_blue);
      logic [BYTE_W-1:0] green, red, blue;
      csr_we <= 1'b0;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - 1){1'b0}}, run};
      // ready is sampled at the falling edge ahead of the edge that takes the beat
      do
         @(negedge clock);
      while (req_tready !== 1'b1);
      @(posedge clock);
      frame_colors(run, green, red, blue);
      if (typed) begin
         green = exp_green;
         red   = exp_red;
         blue  = exp_blue;
      end
      queue_frame(green, red, blue);
      ticks_sent++;
      if (!run)
         blanks_sent++;
   endtask

   // register write, the model copy follows at the same edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_SATURATION: sat_val  = value[BYTE_W-1:0];
         CSR_BRIGHTNESS: bri_val  = value[BYTE_W-1:0];
         CSR_HUE_STEP:   step_val = value;
         default: ;     // past the register list, nothing is stored
      endcase
      reg_writes++;
   endtask

   // registers only change once every owed beat has come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      while (bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // receiver: random stalls, one long hold when asked, none in the quiet phase
   // ---------------------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            // the block stalls at its emit step and keeps req_tready low while the sender keeps offering
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // result check: a beat seen with valid and ready at the falling edge is taken
   // at the next rising edge, compare it with the oldest owed byte
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (bytes_due.size() == 0) begin
            $error("beat with nothing owed: data_byte %0d pixel_index %0d",
                   rsp_tdata[7:0], rsp_tdata[12:8]);
            fail_count++;
         end else begin
            next_due = bytes_due.pop_front();
            beats_checked++;
            if (rsp_tdata[7:0] !== next_due.data_byte) begin
               $error("data_byte mismatch: expected %0d, actual %0d",
                      next_due.data_byte, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[12:8] !== next_due.pixel_index) begin
               $error("pixel_index mismatch: expected %0d, actual %0d",
                      next_due.pixel_index, rsp_tdata[12:8]);
               fail_count++;
            end
            if (rsp_tuser !== next_due.channel) begin
               $error("channel mismatch: expected %0d, actual %0d",
                      next_due.channel, rsp_tuser);
               fail_count++;
            end
            if (rsp_tlast !== next_due.is_last) begin
               $error("last mismatch: expected %0d, actual %0d",
                      next_due.is_last, rsp_tlast);
               fail_count++;
            end
            if (rsp_tdata[15:13] !== 3'b000) begin
               $error("pad mismatch: expected 0, actual %0d", rsp_tdata[15:13]);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // hard stop in case the block hangs
   // ---------------------------------------------------------------------------------------
   initial begin
      #(TIMEOUT_NS * 1ns);
      $display("timeout with %0d beats still owed", bytes_due.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [CSR_DATA_W-1:0] sat_pick, bri_pick, step_pick;
      int                    waited;

      // reset values: sat 255, bright 40, hue 0 gives pure red at 40
      add_tick(1'b1, 1'b1, 8'd0, 8'd40, 8'd0);
      // blank frame is all zero and sends the hue home
      add_tick(1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
      add_tick(1'b1, 1'b1, 8'd0, 8'd40, 8'd0);
      add_tick(1'b1, 1'b0, '0, '0, '0);
      // walk every sector start, then wrap past 360
      add_csr(CSR_HUE_STEP, 9'd60);
      add_tick(1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
      repeat (7) add_tick(1'b1, 1'b0, '0, '0, '0);
      // largest step below a full circle lands on 359, the top of the last sector
      add_csr(CSR_HUE_STEP, 9'd359);
      add_tick(1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
      add_tick(1'b1, 1'b0, '0, '0, '0);
      add_tick(1'b1, 1'b0, '0, '0, '0);
      // no saturation at full value: peak channel 255, the others 254
      add_csr(CSR_SATURATION, 9'd0);
      add_csr(CSR_BRIGHTNESS, 9'd255);
      add_tick(1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
      add_tick(1'b1, 1'b1, 8'd254, 8'd255, 8'd254);
      // zero brightness is black whatever the hue
      add_csr(CSR_BRIGHTNESS, 9'd0);
      add_tick(1'b1, 1'b1, 8'd0, 8'd0, 8'd0);
      // full saturation and value, step above 359 must still wrap
      add_csr(CSR_SATURATION, 9'd255);
      add_csr(CSR_BRIGHTNESS, 9'd255);
      add_csr(CSR_HUE_STEP, 9'd511);
      repeat (3) add_tick(1'b1, 1'b0, '0, '0, '0);
      // write past the register list must leave everything as it was
      add_csr(CSR_SPARE, 9'h1FF);
      add_tick(1'b1, 1'b0, '0, '0, '0);
      // mid-range settings
      add_csr(CSR_SATURATION, 9'd128);
      add_csr(CSR_BRIGHTNESS, 9'd200);
      add_csr(CSR_HUE_STEP, 9'd37);
      add_tick(1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
      add_tick(1'b1, 1'b0, '0, '0, '0);
      add_tick(1'b1, 1'b0, '0, '0, '0);

      // single reset at the start of the run
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_CSR) begin
            wait_idle();
            write_reg(directed_rows[n].index, directed_rows[n].value);
         end else begin
            send_tick(directed_rows[n].run, directed_rows[n].typed,
                      directed_rows[n].green, directed_rows[n].red, directed_rows[n].blue);
         end
      end

      // random part, one register setting per phase
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         quiet = (ph == QUIET_PHASE);
         case (ph)
            0: begin
               sat_pick = 9'd255; bri_pick = 9'd255; step_pick = 9'd359;
            end
            1: begin
               sat_pick = '0; bri_pick = '0; step_pick = '0;
            end
            default: begin
               sat_pick  = pick_setting();
               bri_pick  = pick_setting();
               step_pick = pick_setting();
            end
         endcase
         write_reg(CSR_SATURATION, sat_pick);
         write_reg(CSR_BRIGHTNESS, bri_pick);
         write_reg(CSR_HUE_STEP, step_pick);
         if ($urandom_range(3) == 0)
            write_reg(CSR_SPARE, CSR_DATA_W'($urandom_range(2 ** CSR_DATA_W - 1)));
         if (ph == PRESSURE_PHASE)
            hold_off_request = 1'b1;
         repeat (TICKS_PER_PHASE)
            send_tick($urandom_range(99) < RUN_PCT, 1'b0, '0, '0, '0);
      end

      // drain, with a bound so that missing beats are reported as such
      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      quiet       = 1'b0;
      waited      = 0;
      while (bytes_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bytes_due.size() != 0) begin
         $error("%0d owed beats never arrived", bytes_due.size());
         fail_count++;
      end

      $display("covered %0d frame ticks (%0d blank) over %0d register writes",
               ticks_sent, blanks_sent, reg_writes);
      $display("compared %0d colour beats, all six hue sectors, stalls and a long hold",
               beats_checked);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
